FILE: rtl/assert_macros.svh
// assertion macros for the rtl modules, included by bar_dp
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/bar_pkg.sv
// shared constants, register indexes, operation codes and control structs
package bar_pkg;
    localparam int DEF_MAX_TEXT_COLS  = 256;
    localparam int DEF_MAX_BLOCK_SIDE = 64;
    localparam int DEF_MAX_IMAGE_SIDE = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_CFG_W  = 13;
    localparam int TXT_CFG_W  = 9;
    localparam int BLK_CFG_W  = 7;
    localparam int RAMP_W     = 8;
    localparam int PIX_W      = 8;
    localparam int TILE_W     = 8;
    localparam int SYM_W      = 7;

    localparam int FULL_SCALE = 255;
    localparam int SYM_MAX    = 127;

    // divide by three as multiply by 683 and shift by 11, exact for sums up to 765
    localparam int LUM_RECIP  = 683;
    localparam int LUM_SHIFT  = 11;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH  = 3'd6;

    localparam logic [IMG_CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [IMG_CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [TXT_CFG_W-1:0] RST_TEXT_COLS    = 9'd80;
    localparam logic [TXT_CFG_W-1:0] RST_TEXT_ROWS    = 9'd40;
    localparam logic [BLK_CFG_W-1:0] RST_BLOCK_WIDTH  = 7'd8;
    localparam logic [BLK_CFG_W-1:0] RST_BLOCK_HEIGHT = 7'd12;
    localparam logic [RAMP_W-1:0]    RST_RAMP_LENGTH  = 8'd10;

    // divider operations, in the order the controller issues them
    localparam logic [2:0] OP_COL  = 3'd0;
    localparam logic [2:0] OP_ROW  = 3'd1;
    localparam logic [2:0] OP_RED  = 3'd2;
    localparam logic [2:0] OP_GRN  = 3'd3;
    localparam logic [2:0] OP_BLU  = 3'd4;
    localparam logic [2:0] OP_STEP = 3'd5;
    localparam logic [2:0] OP_SYM  = 3'd6;

    typedef struct packed {
        logic       capture;
        logic       div_start;
        logic       div_latch;
        logic [2:0] op;
        logic       mem_rd;
        logic       acc;
        logic       out_load;
        logic       advance;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic in_range;
        logic last_px;
        logic out_full;
    } t_sts;
endpackage

FILE: rtl/bar_div.sv
// restoring divider, one quotient bit per cycle
module bar_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             qbit;

    // trial subtract of the shifted partial remainder
    always_comb begin
        trial = {r_rem, r_quot[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        qbit  = (trial >= {1'b0, r_dvs});
    end

    // control: iteration count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient shifts in from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DVD_W-2:0], qbit};
            r_rem  <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

FILE: rtl/bar_ctrl.sv
// sequencing state machine for one pixel beat
module bar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bar_pkg::t_sts i_sts,
    output bar_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DST  = 3'd1;
    localparam logic [2:0] S_DWT  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_ADV  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_op, n_op;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_op    = bar_pkg::OP_COL;
                    n_state = S_DST;
                end
            end
            S_DST: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DWT;
            end
            S_DWT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_latch = 1'b1;
                    case (r_op)
                        bar_pkg::OP_ROW:  n_state = S_CHK;
                        bar_pkg::OP_SYM:  n_state = S_OUT;
                        default: begin
                            n_op    = r_op + 1'b1;
                            n_state = S_DST;
                        end
                    endcase
                end
            end
            S_CHK: begin
                n_state = i_sts.in_range ? S_RD : S_ADV;
            end
            S_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.last_px) begin
                    n_op    = bar_pkg::OP_RED;
                    n_state = S_DST;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= bar_pkg::OP_COL;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_stall = (r_state != S_IDLE);
endmodule

FILE: rtl/bar_dp.sv
// datapath: registers, position counters, tile sums memory and divider
`include "assert_macros.svh"
module bar_dp #(
    parameter int MAX_TEXT_COLS  = bar_pkg::DEF_MAX_TEXT_COLS,
    parameter int MAX_BLOCK_SIDE = bar_pkg::DEF_MAX_BLOCK_SIDE,
    parameter int MAX_IMAGE_SIDE = bar_pkg::DEF_MAX_IMAGE_SIDE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bar_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bar_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [bar_pkg::PIX_W-1:0]         i_red,
    input  logic [bar_pkg::PIX_W-1:0]         i_green,
    input  logic [bar_pkg::PIX_W-1:0]         i_blue,
    input  logic                              i_frame_start,
    input  logic                              i_out_stall,
    input  bar_pkg::t_cmd                     i_cmd,
    output bar_pkg::t_sts                     o_sts,
    output logic                              o_valid,
    output logic [bar_pkg::TILE_W-1:0]        o_tile_row,
    output logic [bar_pkg::TILE_W-1:0]        o_tile_col,
    output logic [bar_pkg::PIX_W-1:0]         o_mean_red,
    output logic [bar_pkg::PIX_W-1:0]         o_mean_green,
    output logic [bar_pkg::PIX_W-1:0]         o_mean_blue,
    output logic [bar_pkg::PIX_W-1:0]         o_luminance,
    output logic [bar_pkg::SYM_W-1:0]         o_symbol_index
);
    localparam int PW     = bar_pkg::PIX_W;
    localparam int POS_W  = $clog2(MAX_IMAGE_SIDE);
    localparam int BS_W   = $clog2(MAX_BLOCK_SIDE + 1);
    localparam int AREA_W = $clog2(MAX_BLOCK_SIDE * MAX_BLOCK_SIDE + 1);
    localparam int SUM_W  = $clog2(255 * MAX_BLOCK_SIDE * MAX_BLOCK_SIDE + 1);
    localparam int TC_AW  = (MAX_TEXT_COLS > 1) ? $clog2(MAX_TEXT_COLS) : 1;
    localparam int DVD_A  = (SUM_W > POS_W) ? SUM_W : POS_W;
    localparam int DVD_W  = (DVD_A > 10) ? DVD_A : 10;
    localparam int DVS_W  = (AREA_W > PW) ? AREA_W : PW;
    localparam int LP_W   = 2 * PW + 4;

    // configuration registers
    logic [bar_pkg::IMG_CFG_W-1:0] r_img_w, r_img_h;
    logic [bar_pkg::TXT_CFG_W-1:0] r_txt_c, r_txt_r;
    logic [bar_pkg::BLK_CFG_W-1:0] r_blk_w, r_blk_h;
    logic [bar_pkg::RAMP_W-1:0]    r_ramp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= bar_pkg::RST_IMAGE_WIDTH;
            r_img_h <= bar_pkg::RST_IMAGE_HEIGHT;
            r_txt_c <= bar_pkg::RST_TEXT_COLS;
            r_txt_r <= bar_pkg::RST_TEXT_ROWS;
            r_blk_w <= bar_pkg::RST_BLOCK_WIDTH;
            r_blk_h <= bar_pkg::RST_BLOCK_HEIGHT;
            r_ramp  <= bar_pkg::RST_RAMP_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bar_pkg::REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[bar_pkg::IMG_CFG_W-1:0];
                bar_pkg::REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[bar_pkg::IMG_CFG_W-1:0];
                bar_pkg::REG_TEXT_COLS:    r_txt_c <= i_cfg_data[bar_pkg::TXT_CFG_W-1:0];
                bar_pkg::REG_TEXT_ROWS:    r_txt_r <= i_cfg_data[bar_pkg::TXT_CFG_W-1:0];
                bar_pkg::REG_BLOCK_WIDTH:  r_blk_w <= i_cfg_data[bar_pkg::BLK_CFG_W-1:0];
                bar_pkg::REG_BLOCK_HEIGHT: r_blk_h <= i_cfg_data[bar_pkg::BLK_CFG_W-1:0];
                bar_pkg::REG_RAMP_LENGTH:  r_ramp  <= i_cfg_data[bar_pkg::RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped sizes: zero acts as one, oversize acts as the maximum
    logic [31:0]         w_c, h_c;
    logic [BS_W-1:0]     bw, bh;
    logic [2*BS_W-1:0]   area_full;
    logic [AREA_W-1:0]   area;
    logic [PW-1:0]       len, len_m1;

    always_comb begin
        w_c = (r_img_w == '0) ? 32'd1 :
              (32'(r_img_w) > 32'(MAX_IMAGE_SIDE)) ? 32'(MAX_IMAGE_SIDE) : 32'(r_img_w);
        h_c = (r_img_h == '0) ? 32'd1 :
              (32'(r_img_h) > 32'(MAX_IMAGE_SIDE)) ? 32'(MAX_IMAGE_SIDE) : 32'(r_img_h);
        bw  = (r_blk_w == '0) ? BS_W'(1) :
              (32'(r_blk_w) > 32'(MAX_BLOCK_SIDE)) ? BS_W'(MAX_BLOCK_SIDE) : BS_W'(r_blk_w);
        bh  = (r_blk_h == '0) ? BS_W'(1) :
              (32'(r_blk_h) > 32'(MAX_BLOCK_SIDE)) ? BS_W'(MAX_BLOCK_SIDE) : BS_W'(r_blk_h);
        area_full = (2*BS_W)'(bw) * (2*BS_W)'(bh);
        area      = area_full[AREA_W-1:0];
        len    = (r_ramp == '0) ? PW'(1) : r_ramp;
        len_m1 = len - 1'b1;
    end

    // pixel capture and position counters
    logic [POS_W-1:0] r_col, r_row;
    logic [PW-1:0]    r_red, r_green, r_blue;
    logic [POS_W-1:0] col_base, row_base;
    logic [POS_W:0]   col_inc, row_inc;

    always_comb begin
        col_base = i_frame_start ? '0 : r_col;
        row_base = i_frame_start ? '0 : r_row;
        col_inc  = {1'b0, r_col} + 1'b1;
        row_inc  = {1'b0, r_row} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.capture) begin
            r_col <= (32'(col_base) >= w_c) ? '0 : col_base;
            r_row <= (32'(row_base) >= h_c) ? '0 : row_base;
        end else if (i_cmd.advance) begin
            if (32'(col_inc) >= w_c) begin
                r_col <= '0;
                r_row <= (32'(row_inc) >= h_c) ? '0 : row_inc[POS_W-1:0];
            end else begin
                r_col <= col_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    // shared divider and its operand selection
    logic [POS_W-1:0] r_tc, r_tr;
    logic [BS_W-1:0]  r_xin, r_yin;
    logic [SUM_W-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic [PW-1:0]    r_mr, r_mg, r_mb, r_lum, r_step;
    logic [bar_pkg::SYM_W-1:0] r_sym;
    logic [DVD_W-1:0] dvd, quot;
    logic [DVS_W-1:0] dvs, rem;
    logic             div_busy, div_done;
    logic [PW+1:0]    mean_sum;
    logic [LP_W-1:0]  lum_prod;
    logic [PW-1:0]    lum_q;

    // luminance: sum of means divided by three through a reciprocal multiply
    always_comb begin
        mean_sum = (PW+2)'(r_mr) + (PW+2)'(r_mg) + (PW+2)'(r_mb);
        lum_prod = LP_W'(mean_sum) * LP_W'(bar_pkg::LUM_RECIP);
        lum_q    = lum_prod[bar_pkg::LUM_SHIFT+PW-1:bar_pkg::LUM_SHIFT];
    end

    always_comb begin
        case (i_cmd.op)
            bar_pkg::OP_COL:  begin dvd = DVD_W'(r_col);   dvs = DVS_W'(bw);   end
            bar_pkg::OP_ROW:  begin dvd = DVD_W'(r_row);   dvs = DVS_W'(bh);   end
            bar_pkg::OP_RED:  begin dvd = DVD_W'(r_sum_r); dvs = DVS_W'(area); end
            bar_pkg::OP_GRN:  begin dvd = DVD_W'(r_sum_g); dvs = DVS_W'(area); end
            bar_pkg::OP_BLU:  begin dvd = DVD_W'(r_sum_b); dvs = DVS_W'(area); end
            bar_pkg::OP_STEP: begin
                dvd = DVD_W'(bar_pkg::FULL_SCALE);
                dvs = DVS_W'(len);
            end
            bar_pkg::OP_SYM:  begin dvd = DVD_W'(r_lum);   dvs = DVS_W'(r_step); end
            default:          begin dvd = '0;              dvs = DVS_W'(1);      end
        endcase
    end

    bar_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // quotient clamps
    logic [PW-1:0] q_sat, sym_lim;
    always_comb begin
        q_sat   = (quot > DVD_W'(bar_pkg::FULL_SCALE)) ? PW'(bar_pkg::FULL_SCALE)
                                                       : quot[PW-1:0];
        sym_lim = (quot > DVD_W'(len_m1)) ? len_m1 : quot[PW-1:0];
        if (32'(sym_lim) > 32'(bar_pkg::SYM_MAX)) begin
            sym_lim = PW'(bar_pkg::SYM_MAX);
        end
    end

    // result latching per operation; luminance is taken once all means are in
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_latch) begin
            case (i_cmd.op)
                bar_pkg::OP_COL:  begin r_tc <= quot[POS_W-1:0]; r_xin <= rem[BS_W-1:0]; end
                bar_pkg::OP_ROW:  begin r_tr <= quot[POS_W-1:0]; r_yin <= rem[BS_W-1:0]; end
                bar_pkg::OP_RED:  r_mr   <= q_sat;
                bar_pkg::OP_GRN:  r_mg   <= q_sat;
                bar_pkg::OP_BLU:  r_mb   <= q_sat;
                bar_pkg::OP_STEP: begin
                    r_step <= (quot == '0) ? PW'(1) : q_sat;
                    r_lum  <= lum_q;
                end
                bar_pkg::OP_SYM:  r_sym  <= sym_lim[bar_pkg::SYM_W-1:0];
                default: ;
            endcase
        end
    end

    // tile status
    logic in_range, first_px, last_px;
    always_comb begin
        in_range = (32'(r_tc) < 32'(r_txt_c)) && (32'(r_tr) < 32'(r_txt_r))
                && (32'(r_tc) < 32'(MAX_TEXT_COLS));
        first_px = (r_xin == '0) && (r_yin == '0);
        last_px  = (32'(r_xin) + 32'd1 == 32'(bw)) && (32'(r_yin) + 32'd1 == 32'(bh));
    end

    // per-column tile sums memory, red, green and blue packed in one word
    logic [3*SUM_W-1:0] mem [MAX_TEXT_COLS];
    logic [3*SUM_W-1:0] r_rdata;
    logic [TC_AW-1:0]   addr;
    logic [SUM_W-1:0]   n_sum_r, n_sum_g, n_sum_b;

    always_comb begin
        addr    = TC_AW'(r_tc);
        n_sum_r = first_px ? SUM_W'(r_red)
                           : r_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(r_red);
        n_sum_g = first_px ? SUM_W'(r_green)
                           : r_rdata[2*SUM_W-1:SUM_W] + SUM_W'(r_green);
        n_sum_b = first_px ? SUM_W'(r_blue)
                           : r_rdata[SUM_W-1:0] + SUM_W'(r_blue);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[addr];
        end
        if (i_cmd.acc) begin
            mem[addr] <= {n_sum_r, n_sum_g, n_sum_b};
            r_sum_r   <= n_sum_r;
            r_sum_g   <= n_sum_g;
            r_sum_b   <= n_sum_b;
        end
    end

    // output register
    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_tile_row     <= bar_pkg::TILE_W'(r_tr);
            o_tile_col     <= bar_pkg::TILE_W'(r_tc);
            o_mean_red     <= r_mr;
            o_mean_green   <= r_mg;
            o_mean_blue    <= r_mb;
            o_luminance    <= r_lum;
            o_symbol_index <= r_sym;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_sts.div_done = div_done;
    assign o_sts.in_range = in_range;
    assign o_sts.last_px  = last_px;
    assign o_sts.out_full = r_ovalid;

    // checks
    `ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_cmd.out_load, !r_ovalid)
    `ASSERT_IMP(a_acc_range, i_clk, i_rst_n, i_cmd.acc, in_range)
    `ASSERT_IMP(a_div_idle, i_clk, i_rst_n, i_cmd.div_start, !div_busy)
    `ASSERT_NXT(a_sym_clamp, i_clk, i_rst_n,
        i_cmd.div_latch && (i_cmd.op == bar_pkg::OP_SYM), 32'(r_sym) <= 32'(len_m1))
endmodule

FILE: rtl/box_average_to_ascii_ramp.sv
// top level: tile box average to brightness ramp index
// one pixel beat at a time; each beat runs a column divide and a row divide on the
// shared divider, which gives one quotient bit per cycle of a 20-bit dividend
// a tile's last pixel adds five more divides and an output load, which waits
// while a previous result still sits in the output register
// synchronous active-low reset clears counters, control and output valid, and sets config registers to defaults
module box_average_to_ascii_ramp #(
    parameter int MAX_TEXT_COLS  = bar_pkg::DEF_MAX_TEXT_COLS,
    parameter int MAX_BLOCK_SIDE = bar_pkg::DEF_MAX_BLOCK_SIDE,
    parameter int MAX_IMAGE_SIDE = bar_pkg::DEF_MAX_IMAGE_SIDE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bar_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bar_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bar_pkg::PIX_W-1:0]      i_red,
    input  logic [bar_pkg::PIX_W-1:0]      i_green,
    input  logic [bar_pkg::PIX_W-1:0]      i_blue,
    input  logic                           i_frame_start,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bar_pkg::TILE_W-1:0]     o_tile_row,
    output logic [bar_pkg::TILE_W-1:0]     o_tile_col,
    output logic [bar_pkg::PIX_W-1:0]      o_mean_red,
    output logic [bar_pkg::PIX_W-1:0]      o_mean_green,
    output logic [bar_pkg::PIX_W-1:0]      o_mean_blue,
    output logic [bar_pkg::PIX_W-1:0]      o_luminance,
    output logic [bar_pkg::SYM_W-1:0]      o_symbol_index
);
    bar_pkg::t_cmd cmd;
    bar_pkg::t_sts sts;

    // controller
    bar_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath
    bar_dp #(
        .MAX_TEXT_COLS  (MAX_TEXT_COLS),
        .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE),
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_frame_start  (i_frame_start),
        .i_out_stall    (i_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_tile_row     (o_tile_row),
        .o_tile_col     (o_tile_col),
        .o_mean_red     (o_mean_red),
        .o_mean_green   (o_mean_green),
        .o_mean_blue    (o_mean_blue),
        .o_luminance    (o_luminance),
        .o_symbol_index (o_symbol_index)
    );
endmodule

FILE: tb/sv/box_average_to_ascii_ramp_tb.sv
// testbench for box_average_to_ascii_ramp: tile averages checked against an in-bench predictor
`timescale 1ns / 1ps

module box_average_to_ascii_ramp_tb;

    typedef struct packed {
        logic [bar_pkg::TILE_W-1:0] tile_row;
        logic [bar_pkg::TILE_W-1:0] tile_col;
        logic [bar_pkg::PIX_W-1:0]  mean_red;
        logic [bar_pkg::PIX_W-1:0]  mean_green;
        logic [bar_pkg::PIX_W-1:0]  mean_blue;
        logic [bar_pkg::PIX_W-1:0]  luminance;
        logic [bar_pkg::SYM_W-1:0]  symbol_index;
    } t_tile_avg;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [bar_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [bar_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic [bar_pkg::PIX_W-1:0]      i_red, i_green, i_blue;
    logic                           i_frame_start;
    logic                           o_valid;
    logic                           i_stall;
    t_tile_avg                      got;

    box_average_to_ascii_ramp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .i_frame_start(i_frame_start),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_tile_row(got.tile_row), .o_tile_col(got.tile_col),
        .o_mean_red(got.mean_red), .o_mean_green(got.mean_green),
        .o_mean_blue(got.mean_blue), .o_luminance(got.luminance),
        .o_symbol_index(got.symbol_index)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of registers and accumulators
    int unsigned img_w, img_h, txt_cols, txt_rows, blk_w, blk_h, ramp_len;
    int unsigned red_acc[256], green_acc[256], blue_acc[256];
    int unsigned px_col, px_row;

    t_tile_avg   tile_avgs_due[$];
    int          n_errors = 0;
    int unsigned send_idle_pct = 0;
    int unsigned rx_stall_pct = 0;

    function automatic int unsigned side_limit(int unsigned v, int unsigned top);
        if (v == 0) return 1;
        return (v > top) ? top : v;
    endfunction

    // place one pixel; returns 1 with the tile average when a tile closes
    function automatic bit place_pixel(int unsigned r, int unsigned g, int unsigned b,
                                       bit fs, output t_tile_avg res);
        int unsigned w, h, bw, bh, c, rw, tc, tr, xin, yin;
        int unsigned mr, mg, mb, lum, len, stp, sym;
        bit          closed;
        w = side_limit(img_w, 4096);
        h = side_limit(img_h, 4096);
        bw = side_limit(blk_w, 64);
        bh = side_limit(blk_h, 64);
        closed = 1'b0;
        res = '0;
        if (fs) begin
            px_col = 0;
            px_row = 0;
        end
        if (px_col >= w) px_col = 0;
        if (px_row >= h) px_row = 0;
        c = px_col;
        rw = px_row;
        tc = c / bw;
        tr = rw / bh;
        xin = c % bw;
        yin = rw % bh;
        if (tc < txt_cols && tr < txt_rows && tc < 256) begin
            // tile start overwrites, the rest of the tile adds
            if (xin == 0 && yin == 0) begin
                red_acc[tc] = r;
                green_acc[tc] = g;
                blue_acc[tc] = b;
            end else begin
                red_acc[tc] += r;
                green_acc[tc] += g;
                blue_acc[tc] += b;
            end
            if (xin == bw - 1 && yin == bh - 1) begin
                mr = red_acc[tc] / (bw * bh);
                mg = green_acc[tc] / (bw * bh);
                mb = blue_acc[tc] / (bw * bh);
                if (mr > 255) mr = 255;
                if (mg > 255) mg = 255;
                if (mb > 255) mb = 255;
                lum = (mr + mg + mb) / 3;
                len = (ramp_len == 0) ? 1 : ramp_len;
                stp = 255 / len;
                if (stp == 0) stp = 1;
                sym = lum / stp;
                if (sym > len - 1) sym = len - 1;
                if (sym > 127) sym = 127;
                res.tile_row = tr[7:0];
                res.tile_col = tc[7:0];
                res.mean_red = mr[7:0];
                res.mean_green = mg[7:0];
                res.mean_blue = mb[7:0];
                res.luminance = lum[7:0];
                res.symbol_index = sym[6:0];
                closed = 1'b1;
            end
        end
        px_col = c + 1;
        if (px_col >= w) begin
            px_col = 0;
            px_row = rw + 1;
            if (px_row >= h) px_row = 0;
        end
        return closed;
    endfunction

    // register write, only while idle
    task automatic write_reg(logic [bar_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[bar_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bar_pkg::REG_IMAGE_WIDTH:  img_w = val & 32'h1FFF;
            bar_pkg::REG_IMAGE_HEIGHT: img_h = val & 32'h1FFF;
            bar_pkg::REG_TEXT_COLS:    txt_cols = val & 32'h1FF;
            bar_pkg::REG_TEXT_ROWS:    txt_rows = val & 32'h1FF;
            bar_pkg::REG_BLOCK_WIDTH:  blk_w = val & 32'h7F;
            bar_pkg::REG_BLOCK_HEIGHT: blk_h = val & 32'h7F;
            bar_pkg::REG_RAMP_LENGTH:  ramp_len = val & 32'hFF;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned tcs,
                                int unsigned trs, int unsigned bw, int unsigned bh,
                                int unsigned rl);
        write_reg(bar_pkg::REG_IMAGE_WIDTH, w);
        write_reg(bar_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(bar_pkg::REG_TEXT_COLS, tcs);
        write_reg(bar_pkg::REG_TEXT_ROWS, trs);
        write_reg(bar_pkg::REG_BLOCK_WIDTH, bw);
        write_reg(bar_pkg::REG_BLOCK_HEIGHT, bh);
        write_reg(bar_pkg::REG_RAMP_LENGTH, rl);
    endtask

    // send one pixel beat and log the tile average it closes
    task automatic send_pixel(int unsigned r, int unsigned g, int unsigned b, bit fs);
        t_tile_avg res;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_red <= r[7:0];
        i_green <= g[7:0];
        i_blue <= b[7:0];
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_stall);
        if (place_pixel(r, g, b, fs, res)) tile_avgs_due.push_back(res);
    endtask

    // wait for all tile averages, then let trailing pixels drain
    task automatic drain();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (tile_avgs_due.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic send_frame(int unsigned n, bit solid, int unsigned level);
        for (int i = 0; i < n; i++) begin
            if (solid) send_pixel(level, level, level, i == 0);
            else send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                            i == 0);
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (tile_avgs_due.size() == 0) begin
                $display("%0t: unexpected tile beat %p", $realtime, got);
                n_errors++;
            end else begin
                if (got !== tile_avgs_due[0]) begin
                    $display("%0t: tile mismatch expected %p actual %p",
                             $realtime, tile_avgs_due[0], got);
                    n_errors++;
                end
                void'(tile_avgs_due.pop_front());
            end
        end
    end

    task automatic test_default_regs();
        // default geometry closes no tile in a few pixels
        send_frame(20, 1'b0, 0);
        drain();
    endtask

    task automatic test_pixel_extremes();
        set_geometry(4, 2, 2, 1, 2, 2, 10);
        send_frame(8, 1'b1, 255);
        send_frame(8, 1'b1, 0);
        drain();
        write_reg(bar_pkg::REG_RAMP_LENGTH, 128);
        send_frame(8, 1'b1, 255);
        drain();
        write_reg(bar_pkg::REG_RAMP_LENGTH, 255);
        send_frame(8, 1'b1, 255);
        drain();
        write_reg(bar_pkg::REG_RAMP_LENGTH, 1);
        send_frame(8, 1'b1, 200);
        drain();
    endtask

    task automatic test_zero_regs();
        // zero sides and ramp act as one
        set_geometry(0, 0, 1, 1, 0, 0, 0);
        send_frame(3, 1'b0, 0);
        drain();
        // no tile columns: nothing closes
        set_geometry(4, 4, 0, 2, 1, 1, 10);
        send_frame(10, 1'b0, 0);
        drain();
        write_reg(bar_pkg::REG_TEXT_COLS, 2);
        write_reg(bar_pkg::REG_TEXT_ROWS, 0);
        send_frame(10, 1'b0, 0);
        drain();
    endtask

    task automatic test_oversize_regs();
        set_geometry(8191, 8191, 511, 511, 127, 0, 200);
        send_frame(130, 1'b0, 0);
        drain();
        // tall column of single-pixel tiles: tile_row wraps in 8 bits
        set_geometry(1, 300, 1, 511, 1, 1, 16);
        send_frame(260, 1'b0, 0);
        drain();
        // columns past the accumulator range are dropped
        set_geometry(300, 1, 300, 1, 1, 1, 64);
        send_frame(260, 1'b0, 0);
        drain();
    endtask

    task automatic test_random_frames();
        int unsigned n;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 83; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 83; end
                default: begin send_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            set_geometry($urandom_range(12, 1), $urandom_range(10, 1), $urandom_range(6, 1),
                         $urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(3, 1),
                         $urandom_range(255));
            n = 10 + $urandom_range(10);
            for (int i = 0; i < n; i++) begin
                // mostly well-formed frames, with an occasional restart
                send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                           (i == 0) || ($urandom_range(49) == 0));
                if (ph == 1 && i == n / 2) begin
                    @(posedge i_clk);
                    i_valid <= 1'b0;
                    while (tile_avgs_due.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_red <= '0;
        i_green <= '0;
        i_blue <= '0;
        i_frame_start <= 1'b0;
        i_stall <= 1'b0;
        img_w = 640; img_h = 480; txt_cols = 80; txt_rows = 40;
        blk_w = 8; blk_h = 12; ramp_len = 10;
        px_col = 0; px_row = 0;
        foreach (red_acc[i]) begin
            red_acc[i] = 0;
            green_acc[i] = 0;
            blue_acc[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_regs();
        test_pixel_extremes();
        test_zero_regs();
        test_oversize_regs();
        test_random_frames();
        if (n_errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
